// ===== rtl/stun_message_parser_assert.svh =====
// ----------------------------------------------------------------------------
// STUN message parser assertion macros
// Shared property forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef STUN_MESSAGE_PARSER_ASSERT_SVH
`define STUN_MESSAGE_PARSER_ASSERT_SVH

// Implication in the same cycle, disabled while reset is active.
`define SMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("STUN parser assertion failed");

// Implication into the next cycle, disabled while reset is active.
`define SMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("STUN parser assertion failed");

`endif

// ===== rtl/smp_pkg.sv =====
// ----------------------------------------------------------------------------
// STUN message parser package
// Word types, record kinds, address families, parse status codes and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package smp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_datagram;
    } in_t;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [15:0] port;
        logic [1:0]  addr_family;
        logic [1:0]  parse_status;
        logic        last_record;
    } out_t;

    localparam logic [3:0] KIND_HEADER      = 4'd0;
    localparam logic [3:0] KIND_MAPPED      = 4'd1;
    localparam logic [3:0] KIND_PEER        = 4'd2;
    localparam logic [3:0] KIND_RELAYED     = 4'd3;
    localparam logic [3:0] KIND_PRIORITY    = 4'd4;
    localparam logic [3:0] KIND_LIFETIME    = 4'd5;
    localparam logic [3:0] KIND_USECAND     = 4'd6;
    localparam logic [3:0] KIND_CONTROLLING = 4'd7;
    localparam logic [3:0] KIND_CONTROLLED  = 4'd8;
    localparam logic [3:0] KIND_ERROR       = 4'd9;
    localparam logic [3:0] KIND_CONNID      = 4'd10;
    localparam logic [3:0] KIND_INTEGRITY   = 4'd11;
    localparam logic [3:0] KIND_FINGERPRINT = 4'd12;
    localparam logic [3:0] KIND_END         = 4'd13;

    localparam logic [1:0] FAM_IPV4     = 2'd0;
    localparam logic [1:0] FAM_IPV6     = 2'd1;
    localparam logic [1:0] FAM_UNUSABLE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_COOKIE    = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
    localparam logic [15:0] ATTR_XOR_PEER    = 16'h0012;
    localparam logic [15:0] ATTR_XOR_RELAYED = 16'h0016;
    localparam logic [15:0] ATTR_PRIORITY    = 16'h0024;
    localparam logic [15:0] ATTR_LIFETIME    = 16'h000D;
    localparam logic [15:0] ATTR_USECAND     = 16'h0025;
    localparam logic [15:0] ATTR_CONTROLLING = 16'h802A;
    localparam logic [15:0] ATTR_CONTROLLED  = 16'h8029;
    localparam logic [15:0] ATTR_ERROR       = 16'h0009;
    localparam logic [15:0] ATTR_CONNID      = 16'h002A;
    localparam logic [15:0] ATTR_INTEGRITY   = 16'h0008;
    localparam logic [15:0] ATTR_FINGERPRINT = 16'h8028;

    localparam logic [7:0]  FAMILY_CODE_V4 = 8'h01;
    localparam logic [7:0]  FAMILY_CODE_V6 = 8'h02;
    localparam logic [31:0] MAGIC_COOKIE   = 32'h2112A442;
    localparam logic [16:0] OFFSET_MAX     = 17'h1FFFF;
    localparam int          STORE_DEPTH    = 20;
    localparam int          OUT_DEPTH      = 4;

endpackage

`default_nettype wire

// ===== rtl/stun_message_parser.sv =====
// Records enter the result queue as their byte is accepted; the queue head is offered.
// One byte per cycle unless stalled; up to two records per byte leave one per cycle.
// A four-entry result queue holds records; input stalls only when it has under two free.
// Reset is asynchronous and active low and returns the parser to the header phase.
// The end-of-datagram byte also returns the parse state, not the result queue, to reset.
// ----------------------------------------------------------------------------
// STUN message parser
// Parses a STUN datagram byte by byte into header, attribute and end records.
// ----------------------------------------------------------------------------
`default_nettype none

module stun_message_parser
    import smp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_AHDR   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;

    logic [16:0] off_reg,   off_next;
    logic [15:0] mtype_reg, mtype_next;
    logic [15:0] mlen_reg,  mlen_next;
    logic [31:0] cookie_reg, cookie_next;
    logic [31:0] txu_reg,   txu_next;
    logic [63:0] txl_reg,   txl_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] acode_reg, acode_next;
    logic [15:0] alen_reg,  alen_next;
    logic [15:0] vcnt_reg,  vcnt_next;
    logic [7:0]  store_reg [STORE_DEPTH];
    logic [7:0]  sv [STORE_DEPTH];

    out_t        q_reg [OUT_DEPTH];
    out_t        q_next [OUT_DEPTH];
    logic [2:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        pop;
    logic        fin_go;
    logic        fin_v;
    out_t        fin_rec;
    logic        rec_v;
    out_t        rec;
    out_t        end_rec;
    out_t        r0, r1;
    logic [1:0]  npush;

    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = q_reg[0];
    assign in_ready  = (cnt_reg <= 3'(OUT_DEPTH - 2));

    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            sv[i] = (phase_reg == PH_VALUE && vcnt_reg == 16'(i)) ? in_data.in_byte
                                                                   : store_reg[i];
        end
    end

    function automatic logic [31:0] be32(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d);
        return {a, b, c, d};
    endfunction

    // Builds the record of the attribute that just closed.
    always_comb
    begin
        logic [15:0] err;
        logic [15:0] xport;
        logic        len4, len8, len20;
        err     = 16'(sv[2]) * 16'd100 + 16'(sv[3]);
        xport   = {sv[2], sv[3]} ^ MAGIC_COOKIE[31:16];
        len4    = (alen_next >= 16'd4);
        len8    = (alen_next >= 16'd8);
        len20   = (alen_next >= 16'd20);
        fin_v   = 1'b0;
        fin_rec = '0;
        case (acode_next)
            ATTR_XOR_MAPPED, ATTR_XOR_PEER, ATTR_XOR_RELAYED:
            begin
                fin_v = 1'b1;
                fin_rec.record_kind = (acode_next == ATTR_XOR_MAPPED) ? KIND_MAPPED :
                                      (acode_next == ATTR_XOR_PEER) ? KIND_PEER
                                                                     : KIND_RELAYED;
                fin_rec.addr_family = FAM_UNUSABLE;
                if (len4 && sv[1] == FAMILY_CODE_V4 && len8)
                begin
                    fin_rec.addr_family = FAM_IPV4;
                    fin_rec.port        = xport;
                    fin_rec.value_low   = {32'd0, be32(sv[4], sv[5], sv[6], sv[7])
                                                  ^ MAGIC_COOKIE};
                end
                else if (len4 && sv[1] == FAMILY_CODE_V6 && len20)
                begin
                    fin_rec.addr_family = FAM_IPV6;
                    fin_rec.port        = xport;
                    fin_rec.value_high  = {be32(sv[4], sv[5], sv[6], sv[7]),
                                           be32(sv[8], sv[9], sv[10], sv[11])}
                                          ^ {MAGIC_COOKIE, txu_reg};
                    fin_rec.value_low   = {be32(sv[12], sv[13], sv[14], sv[15]),
                                           be32(sv[16], sv[17], sv[18], sv[19])}
                                          ^ txl_reg;
                end
            end
            ATTR_PRIORITY, ATTR_LIFETIME, ATTR_CONNID:
            begin
                fin_v = len4;
                fin_rec.record_kind = (acode_next == ATTR_PRIORITY) ? KIND_PRIORITY :
                                      (acode_next == ATTR_LIFETIME) ? KIND_LIFETIME
                                                                     : KIND_CONNID;
                fin_rec.value_low = {32'd0, be32(sv[0], sv[1], sv[2], sv[3])};
            end
            ATTR_CONTROLLING, ATTR_CONTROLLED:
            begin
                fin_v = len8;
                fin_rec.record_kind = (acode_next == ATTR_CONTROLLING) ? KIND_CONTROLLING
                                                                        : KIND_CONTROLLED;
                fin_rec.value_low = {be32(sv[0], sv[1], sv[2], sv[3]),
                                     be32(sv[4], sv[5], sv[6], sv[7])};
            end
            ATTR_ERROR:
            begin
                fin_v = len4;
                fin_rec.record_kind = KIND_ERROR;
                fin_rec.value_low   = {48'd0, err};
            end
            ATTR_USECAND:
            begin
                fin_v = 1'b1;
                fin_rec.record_kind = KIND_USECAND;
            end
            ATTR_INTEGRITY:
            begin
                fin_v = 1'b1;
                fin_rec.record_kind = KIND_INTEGRITY;
            end
            ATTR_FINGERPRINT:
            begin
                fin_v = 1'b1;
                fin_rec.record_kind = KIND_FINGERPRINT;
            end
            default:
            begin
                fin_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        logic [7:0]  b;
        logic [16:0] n;
        logic [17:0] limit;
        logic [15:0] vc1;
        logic        go_next;
        b          = in_data.in_byte;
        n          = off_reg;
        off_next   = (n < OFFSET_MAX) ? n + 17'd1 : OFFSET_MAX;
        mtype_next = mtype_reg;
        mlen_next  = mlen_reg;
        cookie_next = cookie_reg;
        txu_next   = txu_reg;
        txl_next   = txl_reg;
        phase_next = phase_reg;
        acode_next = acode_reg;
        alen_next  = alen_reg;
        vcnt_next  = vcnt_reg;
        fin_go     = 1'b0;
        rec_v      = 1'b0;
        rec        = '0;
        go_next    = 1'b0;
        vc1        = vcnt_reg + 16'd1;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (n < 17'd2)
                    mtype_next = {mtype_reg[7:0], b};
                else if (n < 17'd4)
                    mlen_next = {mlen_reg[7:0], b};
                else if (n < 17'd8)
                    cookie_next = {cookie_reg[23:0], b};
                else if (n < 17'd12)
                    txu_next = {txu_reg[23:0], b};
                else
                    txl_next = {txl_reg[55:0], b};
                if (n >= 17'd19)
                begin
                    if (cookie_next == MAGIC_COOKIE)
                    begin
                        rec_v           = 1'b1;
                        rec.record_kind = KIND_HEADER;
                        rec.value_high  = {32'd0, txu_next};
                        rec.value_low   = txl_next;
                        go_next         = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
            end
            PH_AHDR:
            begin
                if (vcnt_reg < 16'd2)
                    acode_next = {acode_reg[7:0], b};
                else
                    alen_next = {alen_reg[7:0], b};
                vcnt_next = vc1;
                if (vc1 >= 16'd4)
                begin
                    vcnt_next = 16'd0;
                    if (alen_next == 16'd0)
                    begin
                        fin_go  = 1'b1;
                        go_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                vcnt_next = vc1;
                if (vc1 == alen_reg)
                begin
                    fin_go = 1'b1;
                    if (alen_reg[1:0] != 2'd0)
                        phase_next = PH_PAD;
                    else
                        go_next = 1'b1;
                end
            end
            PH_PAD:
            begin
                if (off_next[1:0] == 2'd0)
                    go_next = 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (fin_go)
        begin
            rec_v = fin_v;
            rec   = fin_rec;
        end

        if (go_next)
        begin
            limit = 18'd20 + {2'd0, mlen_next};
            if (phase_reg == PH_HEADER ? (18'd24 <= limit)
                                       : ({1'b0, off_next} + 18'd4 <= limit))
            begin
                phase_next = PH_AHDR;
                vcnt_next  = 16'd0;
            end
            else
            begin
                phase_next = PH_TRAIL;
            end
        end

        end_rec             = '0;
        end_rec.record_kind = KIND_END;
        end_rec.value_low   = {48'd0, mtype_next};
        limit               = 18'd20 + {2'd0, mlen_next};
        if (off_next < 17'd20)
            end_rec.parse_status = ST_SHORT;
        else if (cookie_next != MAGIC_COOKIE)
            end_rec.parse_status = ST_COOKIE;
        else if ({1'b0, off_next} < limit)
            end_rec.parse_status = ST_TRUNCATED;
        else
            end_rec.parse_status = ST_OK;
        end_rec.last_record = 1'b1;
    end

    always_comb
    begin
        r0 = rec;
        r1 = end_rec;
        r0.last_record = !in_data.end_of_datagram;
        npush = 2'd0;
        if (accept)
        begin
            if (rec_v && in_data.end_of_datagram)
                npush = 2'd2;
            else if (rec_v)
                npush = 2'd1;
            else if (in_data.end_of_datagram)
            begin
                npush = 2'd1;
                r0    = end_rec;
            end
        end
    end

    always_comb
    begin
        logic [2:0] base;
        base = cnt_reg - {2'd0, pop};
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            if (pop && i + 1 < OUT_DEPTH)
                q_next[i] = q_reg[(i + 1) % OUT_DEPTH];
            else
                q_next[i] = q_reg[i];
            if (npush != 2'd0 && 3'(i) == base)
                q_next[i] = r0;
            else if (npush == 2'd2 && 3'(i) == base + 3'd1)
                q_next[i] = r1;
        end
        cnt_next = base + {1'b0, npush};
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (accept && phase_reg == PH_VALUE && vcnt_reg < 16'(STORE_DEPTH))
            store_reg[vcnt_reg[4:0]] <= in_data.in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            off_reg    <= '0;
            mtype_reg  <= '0;
            mlen_reg   <= '0;
            cookie_reg <= '0;
            txu_reg    <= '0;
            txl_reg    <= '0;
            phase_reg  <= PH_HEADER;
            acode_reg  <= '0;
            alen_reg   <= '0;
            vcnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                if (in_data.end_of_datagram)
                begin
                    off_reg    <= '0;
                    mtype_reg  <= '0;
                    mlen_reg   <= '0;
                    cookie_reg <= '0;
                    txu_reg    <= '0;
                    txl_reg    <= '0;
                    phase_reg  <= PH_HEADER;
                    acode_reg  <= '0;
                    alen_reg   <= '0;
                    vcnt_reg   <= '0;
                end
                else
                begin
                    off_reg    <= off_next;
                    mtype_reg  <= mtype_next;
                    mlen_reg   <= mlen_next;
                    cookie_reg <= cookie_next;
                    txu_reg    <= txu_next;
                    txl_reg    <= txl_next;
                    phase_reg  <= phase_next;
                    acode_reg  <= acode_next;
                    alen_reg   <= alen_next;
                    vcnt_reg   <= vcnt_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smp_checker.sv =====
// ----------------------------------------------------------------------------
// STUN message parser checker
// Port-level properties of the parser, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stun_message_parser_assert.svh"

module smp_checker
    import smp_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire in_t  in_data,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_data
);

    `SMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `SMP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
    `SMP_ASSERT_NOW(a_status_only_end,
                    out_valid && out_data.record_kind != KIND_END,
                    out_data.parse_status == ST_OK)
    `SMP_ASSERT_NEXT(a_end_follows, in_valid && in_ready && in_data.end_of_datagram, out_valid)

endmodule

bind stun_message_parser smp_checker u_smp_checker (.*);

`default_nettype wire

// ===== tb/sv/stun_message_parser_tb.sv =====
// ----------------------------------------------------------------------------
// STUN message parser testbench
// Streams STUN datagrams byte by byte into the parser, predicts every record
// with an independent model of the parsing rules, and checks each record
// field by field under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

class record_scoreboard;
    smp_pkg::out_t expected_q[$];
    int errors;
    int checked;

    bit [16:0] offset;
    bit [15:0] dg_type;
    bit [15:0] msg_len;
    bit [31:0] cookie;
    bit [31:0] txn_hi;
    bit [63:0] txn_lo;
    bit [2:0]  phase;
    bit [15:0] acode;
    bit [15:0] alen;
    bit [15:0] vcount;
    bit [7:0]  vstore [20];
    smp_pkg::out_t pending [$];

    localparam bit [2:0] PH_HEADER = 3'd0;
    localparam bit [2:0] PH_AHDR   = 3'd1;
    localparam bit [2:0] PH_VALUE  = 3'd2;
    localparam bit [2:0] PH_PAD    = 3'd3;
    localparam bit [2:0] PH_TRAIL  = 3'd4;

    function new();
        errors = 0;
        checked = 0;
        clear_state();
    endfunction

    function void clear_state();
        offset = 0;
        dg_type = 0;
        msg_len = 0;
        cookie = 0;
        txn_hi = 0;
        txn_lo = 0;
        phase = PH_HEADER;
        acode = 0;
        alen = 0;
        vcount = 0;
        foreach (vstore[i]) vstore[i] = 0;
    endfunction

    function void emit(bit [3:0] kind, bit [63:0] hi, bit [63:0] lo, bit [15:0] prt,
                       bit [1:0] fam, bit [1:0] st);
        smp_pkg::out_t r;
        r.record_kind = kind;
        r.value_high = hi;
        r.value_low = lo;
        r.port = prt;
        r.addr_family = fam;
        r.parse_status = st;
        r.last_record = 1'b0;
        pending.insert(pending.size(), r);
    endfunction

    function bit [31:0] word32(int i);
        return {vstore[i], vstore[i+1], vstore[i+2], vstore[i+3]};
    endfunction

    function void address_record(bit [3:0] kind);
        bit [15:0] prt;
        prt = {vstore[2], vstore[3]} ^ smp_pkg::MAGIC_COOKIE[31:16];
        if (alen < 4)
            emit(kind, 0, 0, 0, smp_pkg::FAM_UNUSABLE, 0);
        else if (vstore[1] == smp_pkg::FAMILY_CODE_V4 && alen >= 8)
            emit(kind, 0, {32'd0, word32(4) ^ smp_pkg::MAGIC_COOKIE}, prt,
                 smp_pkg::FAM_IPV4, 0);
        else if (vstore[1] == smp_pkg::FAMILY_CODE_V6 && alen >= 20)
            emit(kind, {word32(4), word32(8)} ^ {smp_pkg::MAGIC_COOKIE, txn_hi},
                 {word32(12), word32(16)} ^ txn_lo, prt, smp_pkg::FAM_IPV6, 0);
        else
            emit(kind, 0, 0, 0, smp_pkg::FAM_UNUSABLE, 0);
    endfunction

    function void close_attribute();
        case (acode)
            smp_pkg::ATTR_XOR_MAPPED:  address_record(smp_pkg::KIND_MAPPED);
            smp_pkg::ATTR_XOR_PEER:    address_record(smp_pkg::KIND_PEER);
            smp_pkg::ATTR_XOR_RELAYED: address_record(smp_pkg::KIND_RELAYED);
            smp_pkg::ATTR_PRIORITY:
                if (alen >= 4) emit(smp_pkg::KIND_PRIORITY, 0, word32(0), 0, 0, 0);
            smp_pkg::ATTR_LIFETIME:
                if (alen >= 4) emit(smp_pkg::KIND_LIFETIME, 0, word32(0), 0, 0, 0);
            smp_pkg::ATTR_USECAND: emit(smp_pkg::KIND_USECAND, 0, 0, 0, 0, 0);
            smp_pkg::ATTR_CONTROLLING:
                if (alen >= 8)
                    emit(smp_pkg::KIND_CONTROLLING, 0, {word32(0), word32(4)}, 0, 0, 0);
            smp_pkg::ATTR_CONTROLLED:
                if (alen >= 8)
                    emit(smp_pkg::KIND_CONTROLLED, 0, {word32(0), word32(4)}, 0, 0, 0);
            smp_pkg::ATTR_ERROR:
                if (alen >= 4)
                    emit(smp_pkg::KIND_ERROR, 0, vstore[2] * 64'd100 + vstore[3], 0, 0, 0);
            smp_pkg::ATTR_CONNID:
                if (alen >= 4) emit(smp_pkg::KIND_CONNID, 0, word32(0), 0, 0, 0);
            smp_pkg::ATTR_INTEGRITY: emit(smp_pkg::KIND_INTEGRITY, 0, 0, 0, 0, 0);
            smp_pkg::ATTR_FINGERPRINT: emit(smp_pkg::KIND_FINGERPRINT, 0, 0, 0, 0, 0);
            default: ;
        endcase
    endfunction

    function void advance(bit [16:0] pos);
        if (pos + 32'd4 <= 32'd20 + msg_len)
        begin
            phase = PH_AHDR;
            vcount = 0;
        end
        else
            phase = PH_TRAIL;
    endfunction

    function void note_byte(smp_pkg::in_t w);
        bit [16:0] nxt;
        bit [1:0] st;
        nxt = (offset == smp_pkg::OFFSET_MAX) ? offset : offset + 1;
        pending.delete();
        case (phase)
            PH_HEADER:
            begin
                if (offset < 2) dg_type = {dg_type[7:0], w.in_byte};
                else if (offset < 4) msg_len = {msg_len[7:0], w.in_byte};
                else if (offset < 8) cookie = {cookie[23:0], w.in_byte};
                else if (offset < 12) txn_hi = {txn_hi[23:0], w.in_byte};
                else txn_lo = {txn_lo[55:0], w.in_byte};
                if (offset >= 19)
                begin
                    if (cookie == smp_pkg::MAGIC_COOKIE)
                    begin
                        emit(smp_pkg::KIND_HEADER, {32'd0, txn_hi}, txn_lo, 0, 0, 0);
                        advance(20);
                    end
                    else
                        phase = PH_TRAIL;
                end
            end
            PH_AHDR:
            begin
                if (vcount < 2) acode = {acode[7:0], w.in_byte};
                else alen = {alen[7:0], w.in_byte};
                vcount++;
                if (vcount >= 4)
                begin
                    vcount = 0;
                    if (alen == 0)
                    begin
                        close_attribute();
                        advance(nxt);
                    end
                    else
                        phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (vcount < 20) vstore[vcount] = w.in_byte;
                vcount++;
                if (vcount == alen)
                begin
                    close_attribute();
                    if (alen[1:0] != 0) phase = PH_PAD;
                    else advance(nxt);
                end
            end
            PH_PAD:
                if (nxt[1:0] == 0) advance(nxt);
            default: ;
        endcase
        offset = nxt;
        if (w.end_of_datagram)
        begin
            if (nxt < 20) st = smp_pkg::ST_SHORT;
            else if (cookie != smp_pkg::MAGIC_COOKIE) st = smp_pkg::ST_COOKIE;
            else if (nxt < 32'd20 + msg_len) st = smp_pkg::ST_TRUNCATED;
            else st = smp_pkg::ST_OK;
            emit(smp_pkg::KIND_END, 0, {48'd0, dg_type}, 0, 0, st);
            clear_state();
        end
        if (pending.size() > 0) pending[pending.size()-1].last_record = 1'b1;
        foreach (pending[i]) expected_q.insert(expected_q.size(), pending[i]);
    endfunction

    task check_record(smp_pkg::out_t got);
        smp_pkg::out_t e;
        checked++;
        if (expected_q.size() == 0)
        begin
            report("unexpected record", 0, got.record_kind);
            return;
        end
        e = expected_q.pop_front();
        if (got.record_kind !== e.record_kind) report("record_kind", e.record_kind, got.record_kind);
        if (got.value_high !== e.value_high) report("value_high", e.value_high, got.value_high);
        if (got.value_low !== e.value_low) report("value_low", e.value_low, got.value_low);
        if (got.port !== e.port) report("port", e.port, got.port);
        if (got.addr_family !== e.addr_family) report("addr_family", e.addr_family, got.addr_family);
        if (got.parse_status !== e.parse_status)
            report("parse_status", e.parse_status, got.parse_status);
        if (got.last_record !== e.last_record) report("last_record", e.last_record, got.last_record);
    endtask

    task report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        errors++;
        if (errors <= 40)
            $display("mismatch on %s at record %0d: expected %h, got %h",
                     what, checked, exp_v, got_v);
    endtask
endclass

module stun_message_parser_tb;
    import smp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] ATTR_USERNAME   = 16'h0006;
    localparam logic [15:0] ATTR_UNKNOWN    = 16'hFFFF;
    localparam logic [7:0]  FAMILY_CODE_BAD = 8'h07;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    record_scoreboard sb = new();
    int bytes_sent = 0;
    int datagrams = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit sending_done = 1'b0;
    bit timed_out = 1'b0;
    byte unsigned dgram [$];

    stun_message_parser dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_record(out_data);
    end

    initial
    begin
        int wait_n;
        @(posedge clk);
        while (rst_n == 1'b0) @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (sending_done || $urandom_range(0, 5) == 0) wait_n = 0;
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    task automatic send_byte(byte unsigned b, bit eod, bit no_gap);
        in_t w;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 13);
        if (!no_gap && $urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.in_byte = b;
        w.end_of_datagram = eod;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    task automatic send_dgram(bit no_gap);
        foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1, no_gap);
        datagrams++;
    endtask

    task automatic put8(int v);
        dgram.insert(dgram.size(), 8'(v));
    endtask

    task automatic put16(int v);
        put8(v[15:8]);
        put8(v[7:0]);
    endtask

    task automatic start_msg(bit good_cookie);
        dgram.delete();
        put16($urandom_range(0, 65535));
        put16(0);
        for (int i = 0; i < 4; i++)
            put8(good_cookie ? MAGIC_COOKIE[31 - 8*i -: 8] : $urandom_range(0, 255));
        for (int i = 0; i < 12; i++) put8($urandom_range(0, 255));
    endtask

    task automatic append_attr(logic [15:0] code, int len, int fam);
        put16(code);
        put16(len);
        for (int i = 0; i < len; i++)
        begin
            if (i == 1 && fam >= 0) put8(fam);
            else put8($urandom_range(0, 255));
        end
        while (dgram.size() % 4 != 0) put8($urandom_range(0, 255));
    endtask

    task automatic set_length(int delta);
        int l;
        l = dgram.size() - 20 + delta;
        if (l < 0) l = 0;
        dgram[2] = l[15:8];
        dgram[3] = l[7:0];
    endtask

    function automatic logic [15:0] pick_code();
        logic [15:0] codes [14];
        codes = '{ATTR_XOR_MAPPED, ATTR_XOR_PEER, ATTR_XOR_RELAYED, ATTR_PRIORITY,
                  ATTR_LIFETIME, ATTR_USECAND, ATTR_CONTROLLING, ATTR_CONTROLLED,
                  ATTR_ERROR, ATTR_CONNID, ATTR_INTEGRITY, ATTR_FINGERPRINT,
                  ATTR_USERNAME, ATTR_UNKNOWN};
        return codes[$urandom_range(0, 13)];
    endfunction

    task automatic random_attr();
        logic [15:0] code;
        int len;
        int fam;
        code = pick_code();
        fam = -1;
        case ($urandom_range(0, 5))
            0: len = $urandom_range(0, 3);
            1: len = 4;
            2: len = 8;
            3: len = 20;
            4: len = $urandom_range(0, 24);
            default: len = $urandom_range(20, 40);
        endcase
        if (code == ATTR_XOR_MAPPED || code == ATTR_XOR_PEER || code == ATTR_XOR_RELAYED)
        begin
            fam = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 2);
            if (len >= 2 && $urandom_range(0, 1)) len = (fam == 2) ? 20 : 8;
        end
        append_attr(code, len, fam);
    endtask

    task automatic random_dgram(bit no_gap);
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            dgram.delete();
            n = $urandom_range(1, 19);
            repeat (n) put8($urandom_range(0, 255));
        end
        else
        begin
            start_msg(kind != 1);
            n = $urandom_range(0, 4);
            repeat (n) random_attr();
            case ($urandom_range(0, 7))
                0: set_length($urandom_range(1, 12));
                1: begin set_length(0); repeat ($urandom_range(1, 6))
                       put8($urandom_range(0, 255)); end
                2: set_length(-$urandom_range(1, 6));
                3: begin set_length(0);
                       repeat ($urandom_range(1, 5)) void'(dgram.pop_back()); end
                default: set_length(0);
            endcase
            if (dgram.size() == 0) put8(0);
        end
        send_dgram(no_gap);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dgram.delete();
        put8(8'hFF);
        send_dgram(0);
        start_msg(0);
        send_dgram(0);
        start_msg(1);
        append_attr(ATTR_XOR_MAPPED, 8, FAMILY_CODE_V4);
        append_attr(ATTR_XOR_PEER, 20, FAMILY_CODE_V6);
        append_attr(ATTR_XOR_RELAYED, 8, FAMILY_CODE_BAD);
        append_attr(ATTR_XOR_MAPPED, 2, -1);
        append_attr(ATTR_XOR_PEER, 8, FAMILY_CODE_V6);
        set_length(0);
        send_dgram(0);
        start_msg(1);
        append_attr(ATTR_PRIORITY, 4, -1);
        append_attr(ATTR_LIFETIME, 3, -1);
        append_attr(ATTR_USECAND, 0, -1);
        append_attr(ATTR_CONTROLLING, 8, -1);
        append_attr(ATTR_CONTROLLED, 5, -1);
        append_attr(ATTR_ERROR, 4, -1);
        append_attr(ATTR_CONNID, 4, -1);
        append_attr(ATTR_INTEGRITY, 20, -1);
        append_attr(ATTR_FINGERPRINT, 4, -1);
        append_attr(ATTR_USERNAME, 7, -1);
        append_attr(ATTR_PRIORITY, 30, -1);
        set_length(0);
        put8(8'hAA);
        send_dgram(0);
        start_msg(1);
        append_attr(ATTR_PRIORITY, 4, -1);
        set_length(16);
        send_dgram(0);
        start_msg(1);
        for (int i = 0; i < 20; i++) dgram[i] = 8'hFF;
        for (int i = 0; i < 4; i++) dgram[4+i] = MAGIC_COOKIE[31 - 8*i -: 8];
        append_attr(ATTR_XOR_MAPPED, 20, FAMILY_CODE_V6);
        set_length(0);
        send_dgram(0);
        drain();

        hold_off = 1'b1;
        start_msg(1);
        repeat (6) append_attr(ATTR_USECAND, 0, -1);
        set_length(0);
        send_dgram(1);
        drain();

        while (bytes_sent < 1850)
        begin
            random_dgram($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 40) == 0) drain();
        end
        sending_done = 1'b1;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d datagrams; checked %0d records.",
                 bytes_sent, datagrams, sb.checked);
        if (sb.errors == 0 && sb.expected_q.size() == 0 && !timed_out)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        while (idle_cycles < 2000) @(posedge clk);
        timed_out = 1'b1;
        $display("Watchdog expired with %0d records outstanding.", sb.expected_q.size());
        $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
